FILE: src/tree_lca_parent_table_macros.svh
// assertion macros shared by the node table engine
`ifndef TREE_LCA_PARENT_TABLE_MACROS_SVH
`define TREE_LCA_PARENT_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tlca_pkg.sv
// types and constants for the node table common-ancestor engine
`timescale 1ns / 1ps

package tlca_pkg;

    localparam int ID_BITS    = 16;
    localparam int DEPTH_BITS = 8;
    localparam int STEP_BITS  = DEPTH_BITS + 2;
    localparam int STEP_LIMIT = 2 << DEPTH_BITS;

    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [DEPTH_BITS-1:0] t_dep;
    typedef logic [STEP_BITS-1:0]  t_steps;

    typedef enum logic [1:0] {
        FN_WRITE  = 2'd0,
        FN_COMMON = 2'd1,
        FN_ISANC  = 2'd2,
        FN_HAS    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_NOROOT  = 2'd2
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [15:0] node_a;
        logic [15:0] node_b;
        logic [7:0]  depth_in;
    } t_in;

    typedef struct packed {
        logic [15:0] ancestor_id;
        logic        flag;
        t_status     status;
    } t_out;

    typedef struct packed {
        logic valid;
        t_dep depth;
        t_id  parent;
    } t_entry;

    typedef enum logic [2:0] {
        ADR_IN,
        ADR_IDB,
        ADR_PA,
        ADR_PB
    } t_addr_sel;

    // controller to datapath
    typedef struct packed {
        logic      clear;
        logic      accept;
        t_addr_sel addr_sel;
        logic      upd_a;
        logic      mov_a;
        logic      upd_b;
        logic      mov_b;
        logic      step;
        logic      finish;
        t_status   fin_status;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  rd_valid;
        logic  a_gt_b;
        logic  b_gt_a;
        logic  ids_eq;
        logic  both_root;
        logic  step_max;
        logic  clr_last;
    } t_sts;

endpackage

FILE: src/tlca_datapath.sv
// node table memory, walk registers, step counter and result register
`timescale 1ns / 1ps

module tlca_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlca_pkg::t_in  i_cmd,
    input  tlca_pkg::t_ctl i_ctl,
    output tlca_pkg::t_sts o_sts,
    output tlca_pkg::t_out o_res
);

    tlca_pkg::t_entry r_mem [2**tlca_pkg::ID_BITS];
    tlca_pkg::t_entry r_rdata;

    tlca_pkg::t_func  r_func;
    tlca_pkg::t_id    r_id_a;
    tlca_pkg::t_id    r_id_b;
    tlca_pkg::t_id    r_par_a;
    tlca_pkg::t_id    r_par_b;
    tlca_pkg::t_dep   r_dep_a;
    tlca_pkg::t_dep   r_dep_b;
    tlca_pkg::t_steps r_steps;
    tlca_pkg::t_id    r_clr_idx;
    tlca_pkg::t_out   r_res;

    tlca_pkg::t_id    rd_addr;
    tlca_pkg::t_id    wr_addr;
    tlca_pkg::t_entry wr_data;
    logic             wr_en;
    logic             ids_eq;
    logic             fin_ok;

    always_comb begin
        case (i_ctl.addr_sel)
            tlca_pkg::ADR_IN:  rd_addr = tlca_pkg::t_id'(i_cmd.node_a);
            tlca_pkg::ADR_IDB: rd_addr = r_id_b;
            tlca_pkg::ADR_PA:  rd_addr = r_par_a;
            tlca_pkg::ADR_PB:  rd_addr = r_par_b;
            default:           rd_addr = r_id_a;
        endcase
    end

    // sweep clears valid bits, otherwise a write beat loads one entry
    assign wr_en = i_ctl.clear || (i_ctl.accept && i_cmd.func == tlca_pkg::FN_WRITE);
    assign wr_addr = i_ctl.clear ? r_clr_idx : tlca_pkg::t_id'(i_cmd.node_a);

    always_comb begin
        if (i_ctl.clear) begin
            wr_data = '0;
        end else begin
            wr_data.valid  = 1'b1;
            wr_data.depth  = tlca_pkg::t_dep'(i_cmd.depth_in);
            wr_data.parent = tlca_pkg::t_id'(i_cmd.node_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_ctl.clear) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    assign ids_eq = (r_id_a == r_id_b);
    assign fin_ok = (i_ctl.fin_status == tlca_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_func  <= i_cmd.func;
            r_id_a  <= tlca_pkg::t_id'(i_cmd.node_a);
            r_id_b  <= tlca_pkg::t_id'(i_cmd.node_b);
            r_steps <= '0;
        end
        if (i_ctl.step) begin
            r_steps <= r_steps + 1'b1;
        end
        if (i_ctl.upd_a) begin
            r_par_a <= r_rdata.parent;
            r_dep_a <= r_rdata.depth;
        end
        if (i_ctl.mov_a) begin
            r_id_a <= r_par_a;
        end
        if (i_ctl.upd_b) begin
            r_par_b <= r_rdata.parent;
            r_dep_b <= r_rdata.depth;
        end
        if (i_ctl.mov_b) begin
            r_id_b <= r_par_b;
        end
        if (i_ctl.finish) begin
            r_res.status      <= i_ctl.fin_status;
            r_res.ancestor_id <= (r_func == tlca_pkg::FN_COMMON && fin_ok)
                                 ? 16'(r_id_a) : 16'd0;
            if (r_func == tlca_pkg::FN_HAS) begin
                r_res.flag <= r_rdata.valid;
            end else begin
                r_res.flag <= (r_func == tlca_pkg::FN_ISANC) && fin_ok && ids_eq;
            end
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.rd_valid  = r_rdata.valid;
    assign o_sts.a_gt_b    = (r_dep_a > r_dep_b);
    assign o_sts.b_gt_a    = (r_dep_b > r_dep_a);
    assign o_sts.ids_eq    = ids_eq;
    assign o_sts.both_root = (r_par_a == r_id_a) && (r_par_b == r_id_b);
    assign o_sts.step_max  = (r_steps >= tlca_pkg::t_steps'(tlca_pkg::STEP_LIMIT));
    assign o_sts.clr_last  = &r_clr_idx;
    assign o_res           = r_res;

endmodule

FILE: src/tlca_ctrl.sv
// sequencer for table clearing, entry checks and parent walks
`timescale 1ns / 1ps

module tlca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tlca_pkg::t_func i_func,
    input  tlca_pkg::t_sts  i_sts,
    output tlca_pkg::t_ctl  o_ctl,
    output logic            o_busy,
    output logic            o_strobe
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LDA,
        S_RDB,
        S_LDB,
        S_LIFTA,
        S_LIFTB,
        S_JOIN,
        S_CLA,
        S_UPA,
        S_CLB,
        S_UPB
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    logic   r_joint, n_joint;
    tlca_pkg::t_ctl ctl;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_joint = r_joint;
        ctl     = '0;
        ctl.addr_sel   = tlca_pkg::ADR_IN;
        ctl.fin_status = tlca_pkg::ST_OK;
        case (r_state)
            S_CLEAR: begin
                ctl.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    ctl.accept = 1'b1;
                    n_joint    = 1'b0;
                    if (i_func != tlca_pkg::FN_WRITE) begin
                        n_state = S_LDA;
                    end
                end
            end
            S_LDA: begin
                ctl.upd_a = 1'b1;
                if (i_sts.func == tlca_pkg::FN_HAS) begin
                    ctl.finish = 1'b1;
                end else if (!i_sts.rd_valid) begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = tlca_pkg::ST_UNKNOWN;
                end else begin
                    n_state = S_RDB;
                end
            end
            S_RDB: begin
                ctl.addr_sel = tlca_pkg::ADR_IDB;
                n_state      = S_LDB;
            end
            S_LDB: begin
                ctl.upd_b = 1'b1;
                if (!i_sts.rd_valid) begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = tlca_pkg::ST_UNKNOWN;
                end else if (i_sts.func == tlca_pkg::FN_COMMON) begin
                    n_state = S_LIFTA;
                end else begin
                    n_state = S_LIFTB;
                end
            end
            S_LIFTA: begin
                n_state = i_sts.a_gt_b ? S_CLA : S_LIFTB;
            end
            S_LIFTB: begin
                if (i_sts.b_gt_a) begin
                    n_state = S_CLB;
                end else if (i_sts.func == tlca_pkg::FN_COMMON) begin
                    n_state = S_JOIN;
                end else begin
                    ctl.finish = 1'b1;
                end
            end
            S_JOIN: begin
                if (i_sts.ids_eq) begin
                    ctl.finish = 1'b1;
                end else if (i_sts.both_root) begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = tlca_pkg::ST_NOROOT;
                end else begin
                    n_joint = 1'b1;
                    n_state = S_CLA;
                end
            end
            S_CLA: begin
                if (i_sts.step_max) begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = tlca_pkg::ST_NOROOT;
                end else begin
                    ctl.step     = 1'b1;
                    ctl.addr_sel = tlca_pkg::ADR_PA;
                    n_state      = S_UPA;
                end
            end
            S_UPA: begin
                if (!i_sts.rd_valid) begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = tlca_pkg::ST_UNKNOWN;
                end else begin
                    ctl.upd_a = 1'b1;
                    ctl.mov_a = 1'b1;
                    n_state   = r_joint ? S_CLB : S_LIFTA;
                end
            end
            S_CLB: begin
                if (i_sts.step_max) begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = tlca_pkg::ST_NOROOT;
                end else begin
                    ctl.step     = 1'b1;
                    ctl.addr_sel = tlca_pkg::ADR_PB;
                    n_state      = S_UPB;
                end
            end
            S_UPB: begin
                if (!i_sts.rd_valid) begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = tlca_pkg::ST_UNKNOWN;
                end else begin
                    ctl.upd_b = 1'b1;
                    ctl.mov_b = 1'b1;
                    n_state   = r_joint ? S_JOIN : S_LIFTB;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (ctl.finish) begin
            n_state = S_IDLE;
            n_done  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
            r_joint <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_joint <= n_joint;
        end
    end

    assign o_ctl    = ctl;
    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_done;

endmodule

FILE: src/tree_lca_parent_table.sv
// common-ancestor engine over a parent-pointer node table
// sequence: a write is stored as it is accepted; a query reads node a (presence ends there),
// then node b, lifts the deeper node (only b for is-ancestor), and for common-ancestor runs
// joint rounds of two climbs; climbs capped at 2 << DEPTH_BITS, unknown ids end the walk early
// throughput: one item at a time, single read port; results strobe one cycle, never stalled
// reset: valid bits swept clear one entry a cycle over all 2**ID_BITS entries, busy throughout
`timescale 1ns / 1ps
`include "tree_lca_parent_table_macros.svh"

module tree_lca_parent_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tlca_pkg::t_in  i_cmd,
    output logic           o_busy,
    output logic           o_strobe,
    output tlca_pkg::t_out o_res
);

    tlca_pkg::t_ctl ctl;
    tlca_pkg::t_sts sts;
    logic           in_write;
    logic           in_query;
    logic           anc_set;

    tlca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_func   (i_cmd.func),
        .i_sts    (sts),
        .o_ctl    (ctl),
        .o_busy   (o_busy),
        .o_strobe (o_strobe)
    );

    tlca_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_res   (o_res)
    );

    assign in_write = i_start && !o_busy && (i_cmd.func == tlca_pkg::FN_WRITE);
    assign in_query = i_start && !o_busy && (i_cmd.func != tlca_pkg::FN_WRITE);
    assign anc_set  = o_strobe && (o_res.ancestor_id != 16'd0);

    // one result beat per query, never two in a row
    `LCA_ASSERT_NEXT(a_single_beat, o_strobe, !o_strobe, "back-to-back result beats")
    // a write beat produces no result
    `LCA_ASSERT_NEXT(a_write_silent, in_write, !o_strobe, "result after write beat")
    // a query keeps the block busy while it walks
    `LCA_ASSERT_NEXT(a_query_busy, in_query, o_busy, "query accepted without going busy")
    // a nonzero ancestor id only comes with ok status
    `LCA_ASSERT_NOW(a_anc_ok, anc_set, o_res.status == tlca_pkg::ST_OK, "ancestor id with error status")

endmodule
